FILE: hdl/life_generation_step_macros.svh
// Assertion macros shared by the life generation step RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LIFE_GENERATION_STEP_MACROS_SVH
`define LIFE_GENERATION_STEP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define LGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lgs_pkg.sv
// Shared types and constants for the life generation step block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package lgs_pkg;

  localparam int SIDE_W = 7;
  localparam int POS_W  = 6;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Neighbor counts that give a live cell in the next generation.
  localparam logic [3:0] LIFE_BIRTH   = 4'd3;
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t              req_type;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic                   cell_in;
  } req_word_t;

  typedef struct packed {
    logic cell_out;
    logic out_of_range;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ACCESS,
    ST_ADV_RD,
    ST_ADV_SH,
    ST_ADV_WR
  } ctl_state_t;

  typedef struct packed {
    logic load_req;
    logic adv_init;
    logic adv_rd;
    logic adv_shift;
    logic adv_write;
    logic cell_write;
    logic swap;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    req_kind_t req_type;
    logic      in_range;
    logic      k_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/lgs_ctrl.sv
// Sequencer for the life generation step block.
// Depends on lgs_pkg and life_generation_step_macros.svh.
`default_nettype none
`include "life_generation_step_macros.svh"

module lgs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lgs_pkg::ctrl_sts_t sts,
  output lgs_pkg::ctrl_cmd_t cmd
);
  import lgs_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.req_type) inside
          REQ_WRITE, REQ_READ: begin
            if (sts.in_range) begin
              state_nxt = ST_ACCESS;
            end else begin
              cmd.respond = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end
          REQ_ADVANCE: begin
            cmd.adv_init = 1'b1;
            state_nxt    = ST_ADV_RD;
          end
          default: begin
            cmd.respond = 1'b1;
            state_nxt   = ST_IDLE;
          end
        endcase
      end
      ST_ACCESS: begin
        cmd.cell_write = (sts.req_type == REQ_WRITE);
        cmd.respond    = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_ADV_RD: begin
        cmd.adv_rd = 1'b1;
        state_nxt  = ST_ADV_SH;
      end
      ST_ADV_SH: begin
        cmd.adv_shift = 1'b1;
        state_nxt     = ST_ADV_WR;
      end
      ST_ADV_WR: begin
        cmd.adv_write = 1'b1;
        if (sts.k_last) begin
          cmd.swap    = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_ADV_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LGS_ASSERT_NEXT(a_resp_to_idle, cmd.respond, state_r == ST_IDLE, "respond must end the item")
  `LGS_ASSERT_NEXT(a_adv_loops, (state_r == ST_ADV_WR) && !sts.k_last, state_r == ST_ADV_RD, "advance sweep left early")
  `LGS_ASSERT_NOW(a_swap_resp, cmd.swap, cmd.respond, "swap without result word")

endmodule

`default_nettype wire

FILE: hdl/lgs_dp.sv
// Datapath for the life generation step block: grid memory, row window, neighbor lanes.
// Depends on lgs_pkg and life_generation_step_macros.svh.
`default_nettype none
`include "life_generation_step_macros.svh"

module lgs_dp #(
  parameter int MAX_SIDE = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lgs_pkg::req_word_t           in_word,
  input  logic                         cfg_we,
  input  logic [lgs_pkg::SIDE_W-1:0]   cfg_wdata,
  input  lgs_pkg::ctrl_cmd_t           cmd,
  output lgs_pkg::ctrl_sts_t           sts,
  output logic                         out_strobe,
  output lgs_pkg::rsp_word_t           out_word
);
  import lgs_pkg::*;

  localparam int RW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ROWS = 2 ** RW;
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int EW   = (SW > SIDE_W) ? SW : SIDE_W;

  logic [SIDE_W-1:0]   side_r;
  logic [EW-1:0]       side_ext;
  logic [EW-1:0]       eff_ext;
  logic [SW-1:0]       eff_side;

  req_word_t           req_r;
  logic [RW-1:0]       req_row;
  logic [RW-1:0]       req_col;
  logic                in_range;

  logic                cur_r;

  logic [MAX_SIDE-1:0] mem_r [2*ROWS];
  logic [1:0][ROWS-1:0] vld_r;
  logic [RW-1:0]       rd_row;
  logic [MAX_SIDE-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [MAX_SIDE-1:0] row_data;

  logic [MAX_SIDE-1:0] above_r, mid_r, below_r;
  logic [SW-1:0]       k_r;
  logic [MAX_SIDE-1:0] col_mask;
  logic [MAX_SIDE-1:0] new_row;
  logic [MAX_SIDE-1:0] cell_row;

  logic                wr_en;
  logic                wr_sel;
  logic [RW-1:0]       wr_row;
  logic [MAX_SIDE-1:0] wr_data;

  logic                out_strobe_r;
  rsp_word_t           out_word_r;

  // Side register; the side in use is its value saturated to the grid size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_we) begin
      side_r <= cfg_wdata;
    end
  end

  assign side_ext = EW'(side_r);
  assign eff_ext  = (side_ext > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : side_ext;
  assign eff_side = eff_ext[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
  end

  assign req_row  = RW'(req_r.row);
  assign req_col  = RW'(req_r.col);
  assign in_range = (EW'(req_r.row) < eff_ext) && (EW'(req_r.col) < eff_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= 1'b0;
    end else if (cmd.swap) begin
      cur_r <= ~cur_r;
    end
  end

  // Row-wide memory, both grids; the select bit picks the grid.
  assign rd_row = cmd.adv_rd ? RW'(k_r) : req_row;

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[{cur_r, rd_row}];
    if (wr_en) begin
      mem_r[{wr_sel, wr_row}] <= wr_data;
    end
  end

  // Row valid bits; a row never written since reset or since its grid was retired reads zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[cur_r][rd_row];
      if (cmd.adv_init) begin
        vld_r[~cur_r] <= '0;
      end
      if (wr_en) begin
        vld_r[wr_sel][wr_row] <= 1'b1;
      end
    end
  end

  assign row_data = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    cell_row          = row_data;
    cell_row[req_col] = req_r.cell_in;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = cur_r;
    wr_row  = req_row;
    wr_data = cell_row;
    if (cmd.cell_write) begin
      wr_en = 1'b1;
    end else if (cmd.adv_write && (k_r != '0)) begin
      wr_en   = 1'b1;
      wr_sel  = ~cur_r;
      wr_row  = RW'(k_r - SW'(1));
      wr_data = new_row;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      col_mask[i] = (EW'(i) < eff_ext);
    end
  end

  // Three-row window: above, middle (row being computed), below.
  always_ff @(posedge clk) begin
    if (cmd.adv_init) begin
      above_r <= '0;
      mid_r   <= '0;
      below_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.adv_shift) begin
        above_r <= mid_r;
        mid_r   <= below_r;
        below_r <= (k_r < eff_side) ? (row_data & col_mask) : '0;
      end
      if (cmd.adv_write && (k_r != eff_side)) begin
        k_r <= k_r + SW'(1);
      end
    end
  end

  // One neighbor count and rule per column lane.
  always_comb begin
    logic [MAX_SIDE+1:0] pa;
    logic [MAX_SIDE+1:0] pm;
    logic [MAX_SIDE+1:0] pb;
    logic [3:0]          cnt;
    pa = {1'b0, above_r, 1'b0};
    pm = {1'b0, mid_r, 1'b0};
    pb = {1'b0, below_r, 1'b0};
    for (int i = 0; i < MAX_SIDE; i++) begin
      cnt = 4'(pa[i]) + 4'(pa[i+1]) + 4'(pa[i+2]) + 4'(pm[i]) + 4'(pm[i+2])
          + 4'(pb[i]) + 4'(pb[i+1]) + 4'(pb[i+2]);
      new_row[i] = col_mask[i] &
                   ((cnt == LIFE_BIRTH) | ((cnt == LIFE_SURVIVE) & mid_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_word_r.cell_out     <= (req_r.req_type == REQ_READ) && in_range && row_data[req_col];
      out_word_r.out_of_range <= ((req_r.req_type == REQ_WRITE) ||
                                  (req_r.req_type == REQ_READ)) && !in_range;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_word     = out_word_r;

  assign sts.req_type = req_r.req_type;
  assign sts.in_range = in_range;
  assign sts.k_last   = (k_r == eff_side);

  `LGS_ASSERT_NOW(a_word_excl, out_strobe_r, !(out_word_r.cell_out && out_word_r.out_of_range), "read data on out-of-range word")
  `LGS_ASSERT_NEXT(a_swap_flips, cmd.swap, cur_r != $past(cur_r), "current grid did not flip")
  `LGS_ASSERT_NOW(a_wr_in_range, cmd.cell_write, in_range, "cell write outside active grid")

endmodule

`default_nettype wire

FILE: hdl/life_generation_step.sv
// Top level of the life generation step block: bounded Game of Life grid, double buffered.
// Depends on lgs_pkg, lgs_ctrl, lgs_dp and life_generation_step_macros.svh.
//
//   channel   ports                      moves
//   --------  -------------------------  ----------------------------------------
//   input     start, busy, in_word       one request word when start & !busy
//   result    out_strobe, out_word       one result word, valid for one cycle
//   config    cfg_we, cfg_wdata          grid_side, written when cfg_we is high
//
// Sequence: a read or write passes the dispatch and access states before its registered
// out_strobe; an out-of-range or unused request responds from dispatch. An advance
// sweeps the rows of S = min(grid_side, MAX_SIDE) through its read, shift and write states:
// read each row, shift it into the window, write the finished row above it back.
// Reset is synchronous; per-row valid bits make both grids read as cleared, so no
// clearing pass follows reset. The receiver cannot stall: take each word on its strobe.
`default_nettype none

module life_generation_step #(
  parameter int MAX_SIDE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  lgs_pkg::req_word_t          in_word,
  // result channel
  output logic                        out_strobe,
  output lgs_pkg::rsp_word_t          out_word,
  // configuration
  input  logic                        cfg_we,
  input  logic [lgs_pkg::SIDE_W-1:0]  cfg_wdata
);
  import lgs_pkg::*;

  // Controller drives commands; datapath answers with request kind, range check
  // and end-of-sweep status.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lgs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath holds both grids as rows of MAX_SIDE cells, the three-row window
  // for neighbor counting, the side register and the result word register.
  lgs_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

FILE: bench/life_grid_checker.sv
`timescale 1ns / 1ps
// Checker for life_generation_step: watches the request, result and config ports,
// keeps its own copy of both grids and compares every result word in order.
// Depends on lgs_pkg for the word types and the birth and survival counts.

module life_grid_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  lgs_pkg::req_word_t          in_word,
  input  logic                        out_strobe,
  input  lgs_pkg::rsp_word_t          out_word,
  input  logic                        cfg_we,
  input  logic [lgs_pkg::SIDE_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          pending_words
);
  import lgs_pkg::*;

  localparam int SIDE_MAX   = 64;
  localparam int CELL_COUNT = SIDE_MAX * SIDE_MAX;
  localparam int SHOW_MAX   = 10;

  bit               life_plane [0:1][0:CELL_COUNT-1];
  bit               live_sel;
  logic [SIDE_W-1:0] side_reg;
  rsp_word_t        reply_q [$];
  int               miss_total;

  function automatic int active_side();
    return (side_reg > SIDE_MAX) ? SIDE_MAX : int'(side_reg);
  endfunction

  function automatic int live_around(bit sel, int r, int c, int s);
    int n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
            r + dr < s && c + dc < s)
          n += life_plane[sel][(r + dr) * SIDE_MAX + c + dc];
      end
    end
    return n;
  endfunction

  // Build the next generation in the idle plane, then make it current.
  function automatic void evolve_grid();
    int  s;
    int  n;
    int  idx;
    bit  src;
    bit  alive;
    s   = active_side();
    src = live_sel;
    for (int i = 0; i < CELL_COUNT; i++) life_plane[!src][i] = 1'b0;
    for (int r = 0; r < s; r++) begin
      for (int c = 0; c < s; c++) begin
        idx   = r * SIDE_MAX + c;
        n     = live_around(src, r, c, s);
        alive = life_plane[src][idx];
        life_plane[!src][idx] = (n == LIFE_BIRTH) || (n == LIFE_SURVIVE && alive);
      end
    end
    live_sel = !src;
  endfunction

  function automatic rsp_word_t grid_reply(req_word_t w);
    rsp_word_t rsp;
    int        s;
    int        idx;
    rsp = '0;
    s   = active_side();
    idx = int'(w.row) * SIDE_MAX + int'(w.col);
    case (w.req_type)
      REQ_WRITE, REQ_READ: begin
        if (w.row >= s || w.col >= s) begin
          rsp.out_of_range = 1'b1;
        end else if (w.req_type == REQ_WRITE) begin
          life_plane[live_sel][idx] = w.cell_in;
        end else begin
          rsp.cell_out = life_plane[live_sel][idx];
        end
      end
      REQ_ADVANCE: evolve_grid();
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t next_rsp;
    if (!rst_n) begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        life_plane[0][i] = 1'b0;
        life_plane[1][i] = 1'b0;
      end
      live_sel   = 1'b0;
      side_reg   = SIDE_RESET;
      miss_total = 0;
      reply_q.delete();
    end else begin
      // Retire the result first: a word accepted on this edge cannot be answered yet.
      if (out_strobe === 1'b1) begin
        if (reply_q.size() == 0) begin
          miss_total++;
          if (miss_total <= SHOW_MAX)
            $display("%0t: result word with nothing pending: cell_out=%b out_of_range=%b",
                     $realtime, out_word.cell_out, out_word.out_of_range);
        end else begin
          want = reply_q.pop_front();
          if (out_word.cell_out !== want.cell_out ||
              out_word.out_of_range !== want.out_of_range) begin
            miss_total++;
            if (miss_total <= SHOW_MAX)
              $display("%0t: result mismatch: expected cell_out=%b out_of_range=%b, got %b %b",
                       $realtime, want.cell_out, want.out_of_range,
                       out_word.cell_out, out_word.out_of_range);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        next_rsp = grid_reply(in_word);
        reply_q.insert(reply_q.size(), next_rsp);
      end
      if (cfg_we === 1'b1) side_reg = cfg_wdata;
    end
    fail_count    <= miss_total;
    pending_words <= reply_q.size();
  end

endmodule

FILE: bench/tb_life_generation_step.sv
`timescale 1ns / 1ps
// Testbench top for life_generation_step: clock, reset, request stimulus and verdict.
// Depends on lgs_pkg, the block itself and life_grid_checker for all prediction.

module tb_life_generation_step;
  import lgs_pkg::*;

  // Stall limit set well above the run time of an advance at the largest side.
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  req_word_t          in_word   = '0;
  logic               out_strobe;
  rsp_word_t          out_word;
  logic               cfg_we    = 1'b0;
  logic [SIDE_W-1:0]  cfg_wdata = '0;

  int fail_count;
  int pending_words;
  int idle_cycles;
  int burst_left;

  // Side settings for the random phases: tiny grids dominate so advances stay
  // cheap, with the full grid, an empty grid and two oversized values mixed in.
  int side_plan [12] = '{5, 3, 8, 1, 64, 2, 127, 0, 4, 16, 6, 100};

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  life_generation_step DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  life_grid_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_word       (in_word),
    .out_strobe    (out_strobe),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Watchdog: restart on every accepted word in either direction; end the run
  // if the block goes quiet for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request word, hold it until the block takes it, then either keep
  // start high for the next word of the burst or drop it for a random gap.
  task automatic send_word(input req_kind_t kind, input int r, input int c, input bit val);
    req_word_t w;
    int        gap;
    w.req_type = kind;
    w.row      = r[POS_W-1:0];
    w.col      = c[POS_W-1:0];
    w.cell_in  = val;
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      // Now and then run a long stretch with no gaps at all.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
    end
  endtask

  // Drain the block, then write grid_side while it sits idle.
  task automatic set_side(input int side_val);
    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0 || busy !== 1'b0) @(negedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= side_val[SIDE_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly in range; one coordinate in ten anywhere in the field.
  function automatic int pick_pos(input int eff);
    if (eff == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, eff - 1);
  endfunction

  task automatic random_item(input int eff);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 8)
      send_word(REQ_WRITE, pick_pos(eff), pick_pos(eff), $urandom_range(0, 2) != 0);
    else if (roll < 14)
      send_word(REQ_READ, pick_pos(eff), pick_pos(eff), $urandom_range(0, 1));
    else if (roll < 18)
      send_word(REQ_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
    else
      send_word(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  initial begin
    int eff;
    int seeds;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset side of 64: cleared grid, far corner, a corner
    // birth, the unused request code and a dead write.
    send_word(REQ_READ, 0, 0, 1'b0);
    send_word(REQ_READ, 63, 63, 1'b0);
    send_word(REQ_WRITE, 63, 63, 1'b1);
    send_word(REQ_READ, 63, 63, 1'b0);
    send_word(REQ_WRITE, 0, 0, 1'b1);
    send_word(REQ_WRITE, 0, 1, 1'b1);
    send_word(REQ_WRITE, 1, 0, 1'b1);
    send_word(REQ_ADVANCE, 0, 0, 1'b0);
    send_word(REQ_READ, 1, 1, 1'b0);
    send_word(REQ_READ, 63, 63, 1'b0);
    send_word(REQ_READ, 0, 0, 1'b0);
    send_word(REQ_NONE, 63, 63, 1'b1);
    send_word(REQ_WRITE, 62, 0, 1'b0);

    // Zero side: every access is out of range and an advance empties the grid.
    set_side(0);
    send_word(REQ_WRITE, 0, 0, 1'b1);
    send_word(REQ_READ, 0, 0, 1'b0);
    send_word(REQ_ADVANCE, 0, 0, 1'b0);

    // Oversized side saturates to the full grid.
    set_side(127);
    send_word(REQ_READ, 1, 1, 1'b0);
    send_word(REQ_WRITE, 63, 0, 1'b1);
    send_word(REQ_READ, 63, 0, 1'b0);

    // Single cell grid: a lone cell has no neighbors and dies.
    set_side(1);
    send_word(REQ_WRITE, 0, 0, 1'b1);
    send_word(REQ_READ, 0, 1, 1'b0);
    send_word(REQ_ADVANCE, 0, 0, 1'b0);
    send_word(REQ_READ, 0, 0, 1'b0);

    // Random phases: seed live cells, then mix writes, reads and advances.
    foreach (side_plan[p]) begin
      set_side(side_plan[p]);
      eff   = (side_plan[p] > 64) ? 64 : side_plan[p];
      seeds = (eff == 0) ? 2 : $urandom_range(3, 6);
      repeat (seeds) send_word(REQ_WRITE, pick_pos(eff), pick_pos(eff), 1'b1);
      repeat (6) random_item(eff);
    end

    // Drop start, wait for the last result, then let the block settle.
    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lgs_pkg.sv
hdl/lgs_ctrl.sv
hdl/lgs_dp.sv
hdl/life_generation_step.sv
bench/life_grid_checker.sv
bench/tb_life_generation_step.sv
